### sv/resistive_touch_qualifier_macros.svh
// assertion macros for the touch qualifier, sampled on clk with rst held off
`ifndef RESISTIVE_TOUCH_QUALIFIER_MACROS_SVH
`define RESISTIVE_TOUCH_QUALIFIER_MACROS_SVH

// same-cycle implication
`define RTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rtq_pkg.sv
// ----------------------------------------------------------------------------
// rtq_pkg
// shared widths, constants, codes and types of the resistive touch qualifier
// ----------------------------------------------------------------------------
package rtq_pkg;

  localparam int LEVEL_W   = 10;
  localparam int TICK_W    = 16;
  localparam int COORD_W   = 16;
  localparam int COEF_W    = 32;
  localparam int THR_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = COEF_W + LEVEL_W + 1;
  localparam int ACC_W     = 48;

  localparam int                DELAY_DEPTH_DEF = 4;
  localparam logic [TICK_W-1:0] DEBOUNCE_TICKS  = 16'd20;
  localparam int                FULL_SCALE      = 1024;
  localparam int                FS_SHIFT        = $clog2(FULL_SCALE);
  localparam logic              SWAP_AXES       = 1'b0;

  localparam logic [THR_W-1:0]         THRESHOLD_RST = 11'd950;
  localparam logic signed [COEF_W-1:0] CAL_A_RST     = 32'sd76320;
  localparam logic signed [COEF_W-1:0] CAL_B_RST     = 32'sd3080;
  localparam logic signed [COEF_W-1:0] CAL_C_RST     = -32'sd9475080;
  localparam logic signed [COEF_W-1:0] CAL_D_RST     = -32'sd560;
  localparam logic signed [COEF_W-1:0] CAL_E_RST     = 32'sd60340;
  localparam logic signed [COEF_W-1:0] CAL_F_RST     = -32'sd4360660;
  localparam logic signed [COEF_W-1:0] CAL_DIV_RST   = 32'sd205664;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_CAL_A     = 3'd1,
    REG_CAL_B     = 3'd2,
    REG_CAL_C     = 3'd3,
    REG_CAL_D     = 3'd4,
    REG_CAL_E     = 3'd5,
    REG_CAL_F     = 3'd6,
    REG_CAL_DIV   = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    EV_POSITION = 1'b0,
    EV_RELEASE  = 1'b1
  } event_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PDIV,
    ST_PWAIT,
    ST_CMUL,
    ST_CADD,
    ST_CDIV,
    ST_CWAIT,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      ok;
  } ring_entry_t;

  typedef struct packed {
    logic               start;
    logic [ACC_W-1:0]   dividend;
    logic [COEF_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/rtq_if.sv
// ----------------------------------------------------------------------------
// rtq_sample_if / rtq_report_if
// valid/ready channels for reading sets and touch events
// ----------------------------------------------------------------------------
interface rtq_sample_if;
  logic                         valid;
  logic                         ready;
  logic [rtq_pkg::LEVEL_W-1:0]  z1_level;
  logic [rtq_pkg::LEVEL_W-1:0]  z2_level;
  logic [rtq_pkg::LEVEL_W-1:0]  x_level;
  logic [rtq_pkg::LEVEL_W-1:0]  y_level;
  logic [rtq_pkg::TICK_W-1:0]   now_ticks;

  modport source (output valid, z1_level, z2_level, x_level, y_level, now_ticks,
                  input ready);
  modport sink (input valid, z1_level, z2_level, x_level, y_level, now_ticks,
                output ready);
endinterface

interface rtq_report_if;
  logic                               valid;
  logic                               ready;
  logic                               event_kind;
  logic signed [rtq_pkg::COORD_W-1:0] pos_x;
  logic signed [rtq_pkg::COORD_W-1:0] pos_y;
  logic                               cal_valid;

  modport source (output valid, event_kind, pos_x, pos_y, cal_valid, input ready);
  modport sink (input valid, event_kind, pos_x, pos_y, cal_valid, output ready);
endinterface

### sv/rtq_div.sv
// ----------------------------------------------------------------------------
// rtq_div
// shared unsigned restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module rtq_div (
  input  logic              clk,
  input  logic              rst,
  input  rtq_pkg::div_req_t req,
  output rtq_pkg::div_rsp_t rsp
);
  import rtq_pkg::*;

  localparam int ITERS = ACC_W / 2;
  localparam int CNT_W = $clog2(ITERS);

  logic [ACC_W-1:0]  num, num_next;
  logic [COEF_W-1:0] rem, rem_next;
  logic [COEF_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  always_comb begin
    logic [COEF_W:0] r;
    logic [ACC_W-1:0] n;
    r = {1'b0, rem};
    n = num;
    for (int i = 0; i < 2; i++) begin
      r = {r[COEF_W-1:0], n[ACC_W-1]};
      n = {n[ACC_W-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        n[0] = 1'b1;
      end
    end
    num_next = n;
    rem_next = r[COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= req.dividend;
        rem  <= '0;
        den  <= req.divisor;
      end else if (busy) begin
        num <= num_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = num;

endmodule

### sv/resistive_touch_qualifier.sv
// ----------------------------------------------------------------------------
// resistive_touch_qualifier
// pressure qualification, affine calibration and delayed touch reporting
// ----------------------------------------------------------------------------
// channel  | dir | word
// sample   | in  | z1_level, z2_level, x_level, y_level, now_ticks
// report   | out | event_kind, pos_x, pos_y, cal_valid
// wr_*     | in  | register write: index 0..7, 32-bit data
//
// one sample at a time; ready only while the sequencer is idle
// a touch takes one pressure pass and two calibration passes of the shared divider,
// plus multiply/add steps; no touch or a release takes the pressure pass only, and a
// zero divider skips calibration, storing the point with cal_valid low
// a finished report waits in the output register; the next sample is taken
// meanwhile, stalling only if it must report before the register frees
// synchronous reset clears state and the delay ring and loads register defaults
module resistive_touch_qualifier #(
  parameter int DELAY_DEPTH = rtq_pkg::DELAY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rtq_sample_if.sink                      sample,
  rtq_report_if.source                    report,
  input  logic                            wr_en,
  input  logic [rtq_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [rtq_pkg::COEF_W-1:0]      wr_data
);
  import rtq_pkg::*;

  localparam int SLOT_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(DELAY_DEPTH + 1);

  // configuration
  logic [THR_W-1:0]         press_limit;
  logic signed [COEF_W-1:0] cal_a, cal_b, cal_c, cal_d, cal_e, cal_f, cal_divider;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_limit     <= THRESHOLD_RST;
      cal_a           <= CAL_A_RST;
      cal_b           <= CAL_B_RST;
      cal_c           <= CAL_C_RST;
      cal_d           <= CAL_D_RST;
      cal_e           <= CAL_E_RST;
      cal_f           <= CAL_F_RST;
      cal_divider     <= CAL_DIV_RST;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_THRESHOLD: press_limit     <= wr_data[THR_W-1:0];
        REG_CAL_A:     cal_a           <= wr_data;
        REG_CAL_B:     cal_b           <= wr_data;
        REG_CAL_C:     cal_c           <= wr_data;
        REG_CAL_D:     cal_d           <= wr_data;
        REG_CAL_E:     cal_e           <= wr_data;
        REG_CAL_F:     cal_f           <= wr_data;
        REG_CAL_DIV:   cal_divider     <= wr_data;
        default: ;
      endcase
    end
  end

  // sequencer
  state_t state, state_next;

  logic [LEVEL_W-1:0] z1, z2, xl, yl;
  logic [TICK_W-1:0]  now;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic term, axis, neg_q;
  logic signed [COORD_W-1:0] px, py;
  logic pok;
  logic kind;

  logic               is_down;
  logic [TICK_W-1:0]  last_touch_ticks;
  logic [CNT_W-1:0]   down_count;
  logic [SLOT_W-1:0]  write_slot;
  ring_entry_t        point_ring [DELAY_DEPTH];

  logic rep_valid;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rtq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // pressure and release decisions, used while the pressure quotient lands
  logic [31:0] diff32, rz, pres;
  logic        touch, release_due, ring_full;
  logic [LEVEL_W-1:0] rx, ry;

  assign rx          = SWAP_AXES ? yl : xl;
  assign ry          = SWAP_AXES ? xl : yl;
  assign diff32      = {12'd0, div_rsp.quotient[19:0]} - {22'd0, xl};
  assign rz          = diff32 >> FS_SHIFT;
  assign pres        = 32'(FULL_SCALE) - rz;
  assign touch       = pres > {21'd0, press_limit};
  assign release_due = is_down && ((now - last_touch_ticks) >= DEBOUNCE_TICKS);
  assign ring_full   = !(down_count < CNT_W'(DELAY_DEPTH));

  // saturated calibrated coordinate from the divider result
  logic signed [COORD_W-1:0] coord;
  always_comb begin
    logic [ACC_W-1:0] q, nq;
    q  = div_rsp.quotient;
    nq = -q;
    if (!neg_q) begin
      coord = (q > ACC_W'(32767)) ? 16'sh7fff : q[COORD_W-1:0];
    end else begin
      coord = (q > ACC_W'(32768)) ? 16'sh8000 : nq[COORD_W-1:0];
    end
  end

  // multiplier operands
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [LEVEL_W:0]   mul_b;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (sample.valid) state_next = ST_PMUL;
      ST_PMUL:  state_next = ST_PDIV;
      ST_PDIV:  state_next = ST_PWAIT;
      ST_PWAIT: begin
        if (div_rsp.done) begin
          if (touch) begin
            state_next = (cal_divider == '0) ? ST_STORE : ST_CMUL;
          end else begin
            state_next = release_due ? ST_EMIT : ST_IDLE;
          end
        end
      end
      ST_CMUL:  state_next = ST_CADD;
      ST_CADD:  state_next = term ? ST_CDIV : ST_CMUL;
      ST_CDIV:  state_next = ST_CWAIT;
      ST_CWAIT: if (div_rsp.done) state_next = axis ? ST_STORE : ST_CMUL;
      ST_STORE: state_next = ring_full ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (!rep_valid || report.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [ACC_W-1:0]  acc_mag;
    logic [COEF_W-1:0] div_mag;
    acc_mag          = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    div_mag          = cal_divider[COEF_W-1] ? COEF_W'(-cal_divider) : COEF_W'(cal_divider);
    sample.ready     = (state == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = acc_mag;
    div_req.divisor  = div_mag;
    mul_a            = {{(COEF_W-LEVEL_W){1'b0}}, z2};
    mul_b            = {1'b0, xl};
    case (state)
      ST_PDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{(ACC_W-20){1'b0}}, prod[19:0]};
        div_req.divisor  = {{(COEF_W-LEVEL_W){1'b0}}, z1};
      end
      ST_CDIV: div_req.start = 1'b1;
      ST_CMUL: begin
        mul_a = term ? (axis ? cal_e : cal_b) : (axis ? cal_d : cal_a);
        mul_b = {1'b0, term ? ry : rx};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      is_down          <= 1'b0;
      last_touch_ticks <= '0;
      down_count       <= '0;
      write_slot       <= '0;
      rep_valid        <= 1'b0;
      for (int i = 0; i < DELAY_DEPTH; i++) point_ring[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && (!rep_valid || report.ready)) begin
        rep_valid <= 1'b1;
      end else if (report.ready) begin
        rep_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            z1  <= (sample.z1_level == '0) ? LEVEL_W'(1) : sample.z1_level;
            z2  <= sample.z2_level;
            xl  <= sample.x_level;
            yl  <= sample.y_level;
            now <= sample.now_ticks;
          end
        end
        ST_PMUL, ST_CMUL: prod <= PROD_W'(mul_a * mul_b);
        ST_PWAIT: begin
          if (div_rsp.done) begin
            term <= 1'b0;
            axis <= 1'b0;
            acc  <= ACC_W'(cal_c);
            px   <= '0;
            py   <= '0;
            pok  <= 1'b0;
            if (!touch && release_due) begin
              is_down    <= 1'b0;
              down_count <= '0;
              kind       <= EV_RELEASE;
            end
          end
        end
        ST_CADD: begin
          acc  <= acc + ACC_W'(prod);
          term <= 1'b1;
        end
        ST_CDIV: neg_q <= acc[ACC_W-1] ^ cal_divider[COEF_W-1];
        ST_CWAIT: begin
          if (div_rsp.done) begin
            pok <= 1'b1;
            if (!axis) begin
              px   <= coord;
              axis <= 1'b1;
              term <= 1'b0;
              acc  <= ACC_W'(cal_f);
            end else begin
              py <= coord;
            end
          end
        end
        ST_STORE: begin
          point_ring[write_slot] <= '{px: px, py: py, ok: pok};
          write_slot <= (write_slot == SLOT_W'(DELAY_DEPTH - 1)) ? '0
                                                                 : write_slot + 1'b1;
          is_down          <= 1'b1;
          last_touch_ticks <= now;
          kind             <= EV_POSITION;
          if (!ring_full) down_count <= down_count + 1'b1;
        end
        ST_EMIT: begin
          if (!rep_valid || report.ready) begin
            report.event_kind <= kind;
            report.pos_x      <= point_ring[write_slot].px;
            report.pos_y      <= point_ring[write_slot].py;
            report.cal_valid  <= point_ring[write_slot].ok;
          end
        end
        default: ;
      endcase
    end
  end

  assign report.valid = rep_valid;

`include "resistive_touch_qualifier_macros.svh"

  `RTQ_ASSERT_NEXT(a_one_word_at_a_time, sample.valid && sample.ready, !sample.ready, "sample taken while busy")
  `RTQ_ASSERT_NOW(a_count_bound, 1'b1, down_count <= CNT_W'(DELAY_DEPTH), "down count past ring depth")
  `RTQ_ASSERT_NOW(a_div_idle_start, div_req.start, !div_rsp.busy, "divider restarted while busy")

endmodule
